// ----- hw/rtl/sm3_pkg.sv -----
// sm3 package: digest constants, sizes and round helper functions
// used by the sm3 hash engine and its channel interfaces
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;
    localparam int unsigned WordW   = 32;
    localparam int unsigned DigestN = 8;
    localparam int unsigned BlockN  = 16;

    localparam logic [31:0] TJ_LOW  = 32'h79cc4519;
    localparam logic [31:0] TJ_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    localparam word_t IV [DigestN] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } out_beat_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            return d[63:32];
        end
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/sm3_if.sv -----
// valid/ready channel carrying one payload struct per beat
// depends on sm3_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none
interface sm3_in_if import sm3_pkg::*; ();
    logic     valid;
    logic     ready;
    in_beat_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sm3_out_if import sm3_pkg::*; ();
    logic      valid;
    logic      ready;
    out_beat_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sm3_hash_engine.sv -----
// sm3 hash engine top level: byte packer, padder, round sequencer
// depends on sm3_pkg and the channel interfaces in sm3_if.sv
//
//  channel   dir  beat payload                         when taken
//  in        in   data_word, byte_count, last_word     valid & ready
//  out       out  digest_word, digest_index, last      valid & ready
//
// bytes are packed one per cycle into the block buffer, pausing while a full
// block is compressed; each full block passes through the shared round unit
// (one round per cycle) and then a fold step into the chaining value.
// padding also runs byte by byte: 9 to 72 pad bytes and one or two blocks.
// the 8 digest beats leave through the output register, one per taken beat.
// rst_n clears control and reloads the initial value; no clearing pass.
// in.ready is high only in idle; out stalls simply hold the digest beat.
`timescale 1ns / 1ps
`default_nettype none
module sm3_hash_engine import sm3_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    sm3_in_if.sink   in,
    sm3_out_if.source out
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PACK  = 3'd1; // feed message bytes
    localparam logic [2:0] ST_PAD   = 3'd2; // feed pad / length bytes
    localparam logic [2:0] ST_ROUND = 3'd3; // 64 compression rounds
    localparam logic [2:0] ST_FOLD  = 3'd4; // xor into chaining value
    localparam logic [2:0] ST_EMIT  = 3'd5; // send digest beats

    logic [2:0]  state_reg, state_next;
    word_t       cv_reg [DigestN];
    word_t       buf_reg [BlockN];
    word_t       w_reg [BlockN];
    word_t       r_reg [DigestN];
    logic [5:0]  bytes_reg;       // bytes held in the buffer
    logic [63:0] len_reg;
    logic [63:0] len_snap_reg;    // length latched for the trailer
    logic [5:0]  round_reg;
    logic [31:0] data_reg;
    logic [2:0]  left_reg;        // message bytes still to pack
    logic        last_reg;
    logic [6:0]  pad_reg;         // pad phase: 0 before 0x80, 1 in zero fill, bit 6 in length bytes
    logic        pad_mode_reg;    // round started from padding
    logic [2:0]  idx_reg;
    logic        ovalid_reg;
    out_beat_t   obeat_reg;

    // byte to push this cycle
    logic [7:0] push_byte;
    logic       pad_len_phase;
    logic [2:0] len_sel;
    always_comb
    begin
        pad_len_phase = (pad_reg != 7'd0) && (bytes_reg == 6'd56 || pad_reg[6]);
        len_sel = 3'd0;
        push_byte = data_reg[31:24];
        if (state_reg == ST_PAD)
        begin
            if (pad_reg == 7'd0)
                push_byte = PAD_BYTE;
            else if (bytes_reg >= 6'd56 && pad_reg[6])
            begin
                len_sel = bytes_reg[2:0];
                push_byte = len_snap_reg[63 - {len_sel, 3'b000} -: 8];
            end
            else
                push_byte = 8'd0;
        end
    end

    // round logic
    word_t tj, a12, ss1, ss2, ff, gg, tt1, tt2, wnext;
    always_comb
    begin
        tj  = (round_reg < 6'd16) ? TJ_LOW : TJ_HIGH;
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + rotl(tj, round_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        else
        begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + r_reg[7] + ss1 + w_reg[0];
        wnext = perm1(w_reg[0] ^ w_reg[7] ^ rotl(w_reg[13], 5'd15))
              ^ rotl(w_reg[3], 5'd7) ^ w_reg[10];
    end

    // buffer as it will be after the last byte lands, used to load the window
    word_t buf_bypass [BlockN];
    always_comb
    begin
        for (int i = 0; i < BlockN; i++)
            buf_bypass[i] = buf_reg[i];
        buf_bypass[BlockN - 1][7:0] = push_byte;
    end

    assign in.ready = (state_reg == ST_IDLE);
    assign out.valid = ovalid_reg;
    assign out.payload = obeat_reg;

    logic in_take, out_take;
    assign in_take  = in.valid && in.ready;
    assign out_take = out.valid && out.ready;

    logic [2:0] cnt_clip;
    assign cnt_clip = (in.payload.byte_count > 3'd4) ? 3'd4 : in.payload.byte_count;

    // next-state selection
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_take)
                    state_next = ST_PACK;
            ST_PACK:
                if (left_reg == 3'd0)
                    state_next = last_reg ? ST_PAD : ST_IDLE;
                else if (bytes_reg == 6'd63)
                    state_next = ST_ROUND;
            ST_PAD:
                if (bytes_reg == 6'd63)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            ST_FOLD:
                if (!pad_mode_reg)
                    state_next = ST_PACK;
                else if (pad_reg[6] && bytes_reg == 6'd0 && pad_reg != 7'd0
                         && pad_len_phase)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;
            ST_EMIT:
                if (out_take && idx_reg == 3'd7)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bytes_reg    <= '0;
            len_reg      <= '0;
            round_reg    <= '0;
            left_reg     <= '0;
            last_reg     <= 1'b0;
            pad_reg      <= '0;
            pad_mode_reg <= 1'b0;
            idx_reg      <= '0;
            ovalid_reg   <= 1'b0;
            for (int i = 0; i < DigestN; i++)
                cv_reg[i] <= IV[i];
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (in_take)
                    begin
                        data_reg <= in.payload.data_word;
                        left_reg <= cnt_clip;
                        last_reg <= in.payload.last_word;
                        len_reg  <= len_reg + {58'd0, cnt_clip, 3'b000};
                        len_snap_reg <= len_reg + {58'd0, cnt_clip, 3'b000};
                        pad_reg  <= '0;
                    end
                ST_PACK:
                    if (left_reg != 3'd0)
                    begin
                        buf_reg[bytes_reg[5:2]][31 - {bytes_reg[1:0], 3'b000} -: 8]
                            <= push_byte;
                        data_reg     <= {data_reg[23:0], 8'd0};
                        left_reg     <= left_reg - 3'd1;
                        bytes_reg    <= bytes_reg + 6'd1;
                        pad_mode_reg <= 1'b0;
                    end
                ST_PAD:
                begin
                    buf_reg[bytes_reg[5:2]][31 - {bytes_reg[1:0], 3'b000} -: 8]
                        <= push_byte;
                    bytes_reg    <= bytes_reg + 6'd1;
                    pad_mode_reg <= 1'b1;
                    // pad_reg: 0 before 0x80, then 1; bit 6 set once the
                    // zero fill reached byte 56 and length bytes follow
                    if (pad_reg == 7'd0)
                        pad_reg <= (bytes_reg == 6'd55) ? 7'h41 : 7'd1;
                    else if (!pad_reg[6] && bytes_reg == 6'd55)
                        pad_reg <= 7'h41;
                end
                ST_ROUND:
                begin
                    r_reg[0] <= tt1;
                    r_reg[1] <= r_reg[0];
                    r_reg[2] <= rotl(r_reg[1], 5'd9);
                    r_reg[3] <= r_reg[2];
                    r_reg[4] <= perm0(tt2);
                    r_reg[5] <= r_reg[4];
                    r_reg[6] <= rotl(r_reg[5], 5'd19);
                    r_reg[7] <= r_reg[6];
                    for (int i = 0; i < BlockN - 1; i++)
                        w_reg[i] <= w_reg[i + 1];
                    w_reg[BlockN - 1] <= wnext;
                    round_reg <= round_reg + 6'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < DigestN; i++)
                        cv_reg[i] <= cv_reg[i] ^ r_reg[i];
                    if (state_next == ST_EMIT)
                    begin
                        ovalid_reg <= 1'b1;
                        idx_reg    <= '0;
                        obeat_reg  <= '{cv_reg[0] ^ r_reg[0], 3'd0, 1'b0};
                    end
                end
                ST_EMIT:
                    if (out_take)
                    begin
                        if (idx_reg == 3'd7)
                        begin
                            ovalid_reg <= 1'b0;
                            len_reg    <= '0;
                            bytes_reg  <= '0;
                            last_reg   <= 1'b0;
                            for (int i = 0; i < DigestN; i++)
                                cv_reg[i] <= IV[i];
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            obeat_reg <= '{cv_reg[idx_reg + 3'd1], idx_reg + 3'd1,
                                           (idx_reg == 3'd6)};
                        end
                    end
                default: ;
            endcase
            // block full: load window and working registers, restart rounds
            if ((state_reg == ST_PACK && left_reg != 3'd0 || state_reg == ST_PAD)
                && bytes_reg == 6'd63)
            begin
                round_reg <= '0;
                for (int i = 0; i < BlockN; i++)
                    w_reg[i] <= buf_bypass[i];
                for (int i = 0; i < DigestN; i++)
                    r_reg[i] <= cv_reg[i];
            end
            if (state_reg == ST_PACK && left_reg == 3'd0 && last_reg)
                pad_reg <= '0;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/sm3_checker.sv -----
// port-level checker for the sm3 hash engine, bound to the top level
// depends on sm3_pkg and the channel interfaces
`timescale 1ns / 1ps
`default_nettype none
module sm3_checker import sm3_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] out_index,
    input wire logic out_last
);
    // no new message while digest beats are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input open during digest");
    // last flag only on index seven
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == 3'd7))) else $error("bad last");
    // index advances by one after a taken non-final beat
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid &&
        out_index == $past(out_index) + 3'd1) else $error("index skip");
    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index))
        else $error("beat dropped");
endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .out_index(out.payload.digest_index), .out_last(out.payload.digest_last)
);
`default_nettype wire
